// File: rtl/core/assert_macros.svh
// Assertion helpers used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/ata_pkg.sv
package ata_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int DIFF_W       = SAMPLE_WIDTH + 1;
  localparam int NUM_W        = DIFF_W + 1;
  localparam int FRAC_BITS    = 28 - SAMPLE_WIDTH;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int SUM_W        = SQ_W + 1;
  localparam int RAD_W        = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_STAGES  = (RAD_W + 1) / 2;
  localparam int ITERATIONS   = 20;
  localparam int CORDIC_W     = ROOT_STAGES + 5;
  localparam int Z_W          = 33;
  localparam int PROD_W       = Z_W + 8;
  localparam int ANGLE_SHIFT  = 24;
  localparam int ANGLE_W      = 15;
  localparam int DEG_LIMIT    = 9000;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0: v = 33'sd754974720;  1: v = 33'sd445687602;  2: v = 33'sd235489088;
      3: v = 33'sd119537938;  4: v = 33'sd60000934;   5: v = 33'sd30029717;
      6: v = 33'sd15018523;   7: v = 33'sd7509720;    8: v = 33'sd3754917;
      9: v = 33'sd1877466;    10: v = 33'sd938734;    11: v = 33'sd469367;
      12: v = 33'sd234684;    13: v = 33'sd117342;    14: v = 33'sd58671;
      15: v = 33'sd29335;     16: v = 33'sd14668;     17: v = 33'sd7334;
      18: v = 33'sd3667;      19: v = 33'sd1833;      20: v = 33'sd917;
      21: v = 33'sd458;       22: v = 33'sd229;       23: v = 33'sd115;
      24: v = 33'sd57;        25: v = 33'sd29;        26: v = 33'sd14;
      27: v = 33'sd7;         28: v = 33'sd4;         29: v = 33'sd2;
      30: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ata_sqrt.sv
// Pipelined digit-by-digit square root, one result bit per stage.
module ata_sqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [ata_pkg::RAD_W-1:0]            radicand,
  input  logic signed [ata_pkg::NUM_W-1:0]     num_in,
  output logic                                 out_valid,
  output logic [ata_pkg::ROOT_STAGES-1:0]      root,
  output logic signed [ata_pkg::NUM_W-1:0]     num_out
);
  localparam int N = ata_pkg::ROOT_STAGES;
  localparam int W = ata_pkg::RAD_W;

  logic [W-1:0]                        rem_r  [0:N];
  logic [W-1:0]                        root_r [0:N];
  logic signed [ata_pkg::NUM_W-1:0]    num_r  [0:N];
  logic                                vld    [0:N];

  assign rem_r[0]  = radicand;
  assign root_r[0] = '0;
  assign num_r[0]  = num_in;
  assign vld[0]    = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0] trial;
    assign trial = root_r[k] + BIT;

    // trial subtract, keep or drop this root bit
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k+1] <= num_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial;
          root_r[k+1] <= (root_r[k] >> 1) + BIT;
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = root_r[N][N-1:0];
  assign num_out   = num_r[N];
endmodule

// File: rtl/core/ata_cordic.sv
// Vectoring CORDIC pipeline, then scaling to 0.01 degree with rounding and saturation.
module ata_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [ata_pkg::ROOT_STAGES-1:0]      mag,
  input  logic signed [ata_pkg::NUM_W-1:0]     num,
  output logic                                 out_valid,
  output logic signed [ata_pkg::ANGLE_W-1:0]   angle
);
  localparam int N  = ata_pkg::ITERATIONS;
  localparam int CW = ata_pkg::CORDIC_W;
  localparam int ZW = ata_pkg::Z_W;
  localparam int PW = ata_pkg::PROD_W;

  logic signed [CW-1:0]                x_r   [0:N];
  logic signed [CW-1:0]                y_r   [0:N];
  logic signed [ZW-1:0]                z_r   [0:N];
  logic                                zm_r  [0:N];
  logic signed [ata_pkg::NUM_W-1:0]    num_r [0:N];
  logic                                vld   [0:N];

  assign x_r[0]   = CW'(mag);
  assign y_r[0]   = CW'(num) <<< ata_pkg::FRAC_BITS;
  assign z_r[0]   = '0;
  assign zm_r[0]  = (mag == '0);
  assign num_r[0] = num;
  assign vld[0]   = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zm_r[i+1]  <= zm_r[i];
        num_r[i+1] <= num_r[i];
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ata_pkg::atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ata_pkg::atan_entry(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  // scale by 100
  logic signed [PW-1:0]              prod;
  logic                              prod_zm;
  logic signed [ata_pkg::NUM_W-1:0]  prod_num;
  logic                              prod_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PW'(z_r[N]) * PW'(100);
      prod_zm  <= zm_r[N];
      prod_num <= num_r[N];
    end
  end

  // round half away from zero, saturate, zero-magnitude override
  logic [PW-1:0]                       pmag;
  logic [PW-1:0]                       rnd;
  logic signed [ata_pkg::ANGLE_W+2:0]  sat;
  logic signed [ata_pkg::ANGLE_W-1:0]  angle_next;
  localparam logic signed [ata_pkg::ANGLE_W-1:0] LIM = ata_pkg::ANGLE_W'(ata_pkg::DEG_LIMIT);

  always_comb begin
    pmag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    rnd  = (pmag + (PW'(1) << (ata_pkg::ANGLE_SHIFT - 1))) >> ata_pkg::ANGLE_SHIFT;
    if (rnd > PW'(ata_pkg::DEG_LIMIT)) begin
      sat = (ata_pkg::ANGLE_W+3)'(ata_pkg::DEG_LIMIT);
    end else begin
      sat = (ata_pkg::ANGLE_W+3)'(rnd);
    end
    if (prod[PW-1]) begin
      sat = -sat;
    end
    angle_next = sat[ata_pkg::ANGLE_W-1:0];
    if (prod_zm) begin
      if (prod_num > 0)      angle_next = LIM;
      else if (prod_num < 0) angle_next = -LIM;
      else                   angle_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      prod_vld  <= vld[N];
      out_valid <= prod_vld;
    end
  end
endmodule

// File: rtl/core/accel_tilt_angles_core.sv
// Channel | Dir | Handshake            | Payload
// cfg     | in  | cfg_wr_en            | cfg_index, cfg_wdata
// in      | in  | in_valid / in_ready  | raw_x, raw_y, raw_z
// out     | out | out_valid / out_ready| pitch_angle, roll_angle
//
// One transaction per cycle sustained while out is not stalled; data passes the offset,
// square and sum stages, the 30-stage square root, the 20 CORDIC iterations and scaling.
// Reset clears the offsets and all valid bits; no clearing pass.
// A stall on out freezes the whole pipeline; in_ready drops only then.
`include "assert_macros.svh"
module accel_tilt_angles_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [ata_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ata_pkg::SAMPLE_WIDTH-1:0]        cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_x,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_y,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ata_pkg::ANGLE_W-1:0]      pitch_angle,
  output logic signed [ata_pkg::ANGLE_W-1:0]      roll_angle
);
  localparam int DW = ata_pkg::DIFF_W;

  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] offset_x, offset_y, offset_z;
  logic en;
  logic pitch_valid, roll_valid;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ata_pkg::REG_OFFSET_X: offset_x <= cfg_wdata;
        ata_pkg::REG_OFFSET_Y: offset_y <= cfg_wdata;
        ata_pkg::REG_OFFSET_Z: offset_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: offset removal
  logic signed [DW-1:0] dx, dy, dz;
  logic                 v1, v2, v3;
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'(raw_x) - DW'(offset_x);
      dy <= DW'(raw_y) - DW'(offset_y);
      dz <= DW'(raw_z) - DW'(offset_z);
    end
  end

  // stage 2: squares
  logic [ata_pkg::SQ_W-1:0]          sx, sy, sz;
  logic signed [ata_pkg::NUM_W-1:0]  np2, nr2;
  always_ff @(posedge clk) begin
    if (en) begin
      sx  <= ata_pkg::SQ_W'(dx * dx);
      sy  <= ata_pkg::SQ_W'(dy * dy);
      sz  <= ata_pkg::SQ_W'(dz * dz);
      np2 <= -ata_pkg::NUM_W'(dx);
      nr2 <= ata_pkg::NUM_W'(dy);
    end
  end

  // stage 3: sums, scaled into radicands
  logic [ata_pkg::RAD_W-1:0]         rad_p, rad_r;
  logic signed [ata_pkg::NUM_W-1:0]  np3, nr3;
  always_ff @(posedge clk) begin
    if (en) begin
      rad_p <= ata_pkg::RAD_W'({1'b0, sy} + {1'b0, sz}) << (2 * ata_pkg::FRAC_BITS);
      rad_r <= ata_pkg::RAD_W'({1'b0, sx} + {1'b0, sz}) << (2 * ata_pkg::FRAC_BITS);
      np3   <= np2;
      nr3   <= nr2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  logic                                  sp_v, sr_v;
  logic [ata_pkg::ROOT_STAGES-1:0]       mag_p, mag_r;
  logic signed [ata_pkg::NUM_W-1:0]      np4, nr4;

  ata_sqrt u_sqrt_p (
    .clk, .rst, .en, .in_valid(v3), .radicand(rad_p), .num_in(np3),
    .out_valid(sp_v), .root(mag_p), .num_out(np4)
  );
  ata_sqrt u_sqrt_r (
    .clk, .rst, .en, .in_valid(v3), .radicand(rad_r), .num_in(nr3),
    .out_valid(sr_v), .root(mag_r), .num_out(nr4)
  );

  ata_cordic u_cordic_p (
    .clk, .rst, .en, .in_valid(sp_v), .mag(mag_p), .num(np4),
    .out_valid(pitch_valid), .angle(pitch_angle)
  );
  ata_cordic u_cordic_r (
    .clk, .rst, .en, .in_valid(sr_v), .mag(mag_r), .num(nr4),
    .out_valid(roll_valid), .angle(roll_angle)
  );

  assign out_valid = pitch_valid;

  `ASSERT_CLK(a_lanes_aligned, clk, rst, pitch_valid == roll_valid, "pitch/roll lanes out of step")
  `ASSERT_CLK(a_pitch_range, clk, rst, out_valid |-> (pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000), "pitch out of range")
  `ASSERT_CLK(a_roll_range, clk, rst, out_valid |-> (roll_angle <= 15'sd9000 && roll_angle >= -15'sd9000), "roll out of range")
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "output valid right after reset")
endmodule

// File: tb/accel_tilt_angles_core_checker.sv
module accel_tilt_angles_core_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [ata_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ata_pkg::SAMPLE_WIDTH-1:0]        cfg_wdata,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_x,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_y,
  input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] raw_z,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [ata_pkg::ANGLE_W-1:0]      pitch_angle,
  input  logic signed [ata_pkg::ANGLE_W-1:0]      roll_angle,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      angles_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ata_pkg::*;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
  } angle_pair_t;

  angle_pair_t angle_q[$];
  longint off_x, off_y, off_z;

  // bitwise integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // atan2(a, sqrt(p^2+q^2)) in 0.01 degree via vectoring rotation
  function automatic longint tilt(input longint a, input longint p, input longint q);
    longint mx, my, z, xs, ys, prod, mag, n;
    longint unsigned s;
    s = longint'(p * p) + longint'(q * q);
    mx = longint'(isqrt(s << (2 * FRAC_BITS)));
    my = a <<< FRAC_BITS;
    z = 0;
    if (mx == 0) return a > 0 ? DEG_LIMIT : (a < 0 ? -DEG_LIMIT : 0);
    for (int i = 0; i < ITERATIONS && i < 32; i++) begin
      xs = mx >>> i;
      ys = my >>> i;
      if (my >= 0) begin
        mx += ys; my -= xs; z += longint'(atan_entry(i));
      end else begin
        mx -= ys; my += xs; z -= longint'(atan_entry(i));
      end
    end
    prod = z * 100;
    mag = prod < 0 ? -prod : prod;
    n = (mag + (64'sd1 << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    if (prod < 0) n = -n;
    if (n > DEG_LIMIT) n = DEG_LIMIT;
    if (n < -DEG_LIMIT) n = -DEG_LIMIT;
    return n;
  endfunction

  always @(posedge clk) begin
    longint dx, dy, dz;
    angle_pair_t want;
    if (rst) begin
      off_x <= 0; off_y <= 0; off_z <= 0;
      angle_q.delete();
      fail_count <= 0;
      angles_seen <= 0;
      pending <= 0;
    end else begin
      // offset register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_OFFSET_X: off_x <= longint'($signed(cfg_wdata));
          REG_OFFSET_Y: off_y <= longint'($signed(cfg_wdata));
          REG_OFFSET_Z: off_z <= longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      // predict on each accepted sample
      if (in_valid && in_ready) begin
        dx = longint'(raw_x) - off_x;
        dy = longint'(raw_y) - off_y;
        dz = longint'(raw_z) - off_z;
        want.pitch = ANGLE_W'(tilt(-dx, dy, dz));
        want.roll = ANGLE_W'(tilt(dy, dx, dz));
        angle_q.push_back(want);
      end
      // compare each accepted result
      if (out_valid && out_ready) begin
        angles_seen <= angles_seen + 1;
        if (angle_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = angle_q.pop_front();
          if (want.pitch !== pitch_angle || want.roll !== roll_angle) begin
            if (fail_count < 10)
              $display("mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                       want.pitch, pitch_angle, want.roll, roll_angle);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= angle_q.size();
    end
  end
endmodule

// File: tb/accel_tilt_angles_core_test.sv
module accel_tilt_angles_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ata_pkg::*;

  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_WIDTH-1:0] raw_x = '0, raw_y = '0, raw_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] pitch_angle, roll_angle;
  int fail_count, pending, angles_seen;
  int cycles = 0;
  int rx_mode = 0;  // 0 random stalls, 1 always ready, 2 hold off
  int samples_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  accel_tilt_angles_core dut (.*);

  accel_tilt_angles_core_checker checker_i (.*);

  // receiver ready pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (rx_mode == 2) out_ready <= 1'b0;
    else if (rx_mode == 1) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 9);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("accel_tilt_angles_core test failed");
      $finish;
    end
  end

  // valid stays up after acceptance; the next call or drain() replaces it
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit gaps);
    while (gaps && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_x <= x; raw_y <= y; raw_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axis extremes, zero-magnitude cases
    send_sample(16'h0000, 16'h0000, 16'h0000, 0);
    send_sample(16'h7fff, 16'h0000, 16'h0000, 0);
    send_sample(16'h8000, 16'h0000, 16'h0000, 0);
    send_sample(16'h0000, 16'h7fff, 16'h0000, 0);
    send_sample(16'h0000, 16'h8000, 16'h0000, 0);
    send_sample(16'h0000, 16'h0000, 16'h7fff, 0);
    send_sample(16'h0000, 16'h0000, 16'h8000, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_sample(16'h7fff, 16'h8000, 16'h0001, 0);
    send_sample(16'hffff, 16'h0001, 16'hffff, 0);
    send_sample(16'h0100, 16'h0100, 16'h0000, 0);
    drain();

    // extreme offsets: widest 17-bit differences
    write_offset(REG_OFFSET_X, 16'h8000);
    write_offset(REG_OFFSET_Y, 16'h7fff);
    write_offset(REG_OFFSET_Z, 16'h8000);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 0);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 0);
    send_sample(16'h7fff, 16'h7fff, 16'h8000, 0);
    drain();
    write_offset(REG_UNMAPPED, 16'h1234);  // unmapped index, ignored
    send_sample(16'h0000, 16'h0000, 16'h0000, 0);
    drain();

    // random phases with different offsets
    for (int ph = 0; ph < 5; ph++) begin
      write_offset(REG_OFFSET_X, ph == 0 ? 16'h0 : rand_word());
      write_offset(REG_OFFSET_Y, ph == 0 ? 16'h0 : rand_word());
      write_offset(REG_OFFSET_Z, ph == 0 ? 16'h0 : rand_word());
      rx_mode = (ph == 1) ? 1 : 0;
      for (int k = 0; k < 100; k++) begin
        // long receiver hold-off partway through phase 2
        if (ph == 2 && k == 10) fork
          begin
            rx_mode = 2;
            repeat (200) @(posedge clk);
            rx_mode = 0;
          end
        join_none
        send_sample(rand_word(), rand_word(), rand_word(), ph != 1);
      end
      drain();  // sender pauses until all angles are back
    end

    rx_mode = 1;
    drain();
    $display("covered %0d samples, %0d angle pairs, offset extremes and stalls",
             samples_sent, angles_seen);
    if (fail_count == 0 && pending == 0) $display("accel_tilt_angles_core test passed");
    else $display("accel_tilt_angles_core test failed");
    $finish;
  end
endmodule
